@@ rtl/ttt_pkg.sv @@
package ttt_pkg;

  localparam int PixW              = 14;
  localparam int TexAw             = 16;
  localparam int ByteW             = 8;
  localparam int ModeW             = 2;
  localparam int PixelCountDefault = 16384;

  localparam logic [ModeW-1:0] ModeTexel  = 2'd0;
  localparam logic [ModeW-1:0] ModeMap    = 2'd1;
  localparam logic [ModeW-1:0] ModeUpdate = 2'd2;
  localparam logic [ModeW-1:0] ModeScroll = 2'd3;

  localparam int FadeMul = 5;
  localparam int FadeDiv = 6;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t fade_tab_t [1 << ByteW];

  function automatic fade_tab_t build_fade_tab();
    fade_tab_t tab;
    for (int i = 0; i < (1 << ByteW); i++) begin
      tab[i] = ByteW'((i * FadeMul) / FadeDiv);
    end
    return tab;
  endfunction

  localparam fade_tab_t FadeTab = build_fade_tab();

  typedef struct packed {
    logic             upd;
    logic [PixW-1:0]  pix;
    logic [TexAw-1:0] taddr;
    byte_t            tval;
    byte_t            angle;
    byte_t            depth;
    byte_t            scroll;
  } map_out_t;

  typedef struct packed {
    logic [PixW-1:0] pix;
    byte_t           depth;
    byte_t           texel;
  } tex_out_t;

  typedef struct packed {
    logic            rd;
    logic [PixW-1:0] pix;
  } trail_rd_t;

endpackage

@@ rtl/ttt_if.sv @@
interface ttt_item_if;
  import ttt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [PixW-1:0]   pixel_index;
  logic [TexAw-1:0]  texel_address;
  logic [ByteW-1:0]  texel_value;
  logic [ByteW-1:0]  angle_value;
  logic [ByteW-1:0]  depth_value;

  modport source (
    output valid, mode, pixel_index, texel_address, texel_value, angle_value, depth_value,
    input  ready
  );

  modport sink (
    input  valid, mode, pixel_index, texel_address, texel_value, angle_value, depth_value,
    output ready
  );
endinterface

interface ttt_result_if;
  import ttt_pkg::*;

  logic             valid;
  logic             ready;
  logic [PixW-1:0]  out_index;
  logic [ByteW-1:0] pixel_value;

  modport source (
    output valid, out_index, pixel_value,
    input  ready
  );

  modport sink (
    input  valid, out_index, pixel_value,
    output ready
  );
endinterface

@@ rtl/ttt_map_stage.sv @@
module ttt_map_stage #(
  parameter int PIXEL_COUNT = ttt_pkg::PixelCountDefault
) (
  input  logic              clk,
  input  logic              rst,
  ttt_item_if.sink          item,
  input  logic              busy,
  output logic              s1_valid,
  input  logic              s1_ready,
  output ttt_pkg::map_out_t s1
);
  import ttt_pkg::*;

  localparam int StoreDepth = (PIXEL_COUNT > (1 << PixW)) ? (1 << PixW) : PIXEL_COUNT;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic             accept;
  logic             pix_ok;
  logic             load_en;
  logic [AddrW-1:0] addr;

  byte_t angle_mem [StoreDepth];
  byte_t depth_mem [StoreDepth];
  byte_t angle_q;
  byte_t depth_q;
  byte_t scroll;

  logic             upd1;
  logic [PixW-1:0]  pix1;
  logic [TexAw-1:0] taddr1;
  byte_t            tval1;
  byte_t            scroll1;

  assign load_en    = !s1_valid || s1_ready;
  assign item.ready = load_en && !busy;
  assign accept     = item.valid && item.ready;
  assign pix_ok     = 32'(item.pixel_index) < 32'(PIXEL_COUNT);
  assign addr       = item.pixel_index[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      scroll   <= '0;
    end else begin
      if (accept && item.mode == ModeScroll) begin
        scroll <= scroll + ByteW'(1);
      end
      if (load_en) begin
        s1_valid <= accept && (item.mode == ModeTexel || (item.mode == ModeUpdate && pix_ok));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upd1    <= (item.mode == ModeUpdate);
      pix1    <= item.pixel_index;
      taddr1  <= item.texel_address;
      tval1   <= item.texel_value;
      scroll1 <= scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.mode == ModeMap && pix_ok) begin
      angle_mem[addr] <= item.angle_value;
      depth_mem[addr] <= item.depth_value;
    end
    if (accept && item.mode == ModeUpdate) begin
      angle_q <= angle_mem[addr];
      depth_q <= depth_mem[addr];
    end
  end

  assign s1 = '{upd: upd1, pix: pix1, taddr: taddr1, tval: tval1,
                angle: angle_q, depth: depth_q, scroll: scroll1};

`ifndef SYNTH
  a_scroll_step: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode == ModeScroll) |=> (scroll == $past(scroll) + ByteW'(1)))
    else $error("scroll did not advance by one on a tick");
`endif

endmodule

@@ rtl/ttt_tex_stage.sv @@
module ttt_tex_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  ttt_pkg::map_out_t  s1,
  output logic               s2_valid,
  input  logic               s2_ready,
  output ttt_pkg::tex_out_t  s2,
  output ttt_pkg::trail_rd_t trd
);
  import ttt_pkg::*;

  logic             xfer;
  byte_t            u;
  byte_t            v;
  logic [TexAw-1:0] rd_addr;

  byte_t           tex_mem [1 << TexAw];
  byte_t           tex_q;
  logic [PixW-1:0] pix2;
  byte_t           depth2;

  assign s1_ready = !s2_valid || s2_ready;
  assign xfer     = s1_valid && s1_ready;
  assign u        = s1.angle + s1.scroll;
  assign v        = s1.depth + s1.scroll;
  assign rd_addr  = {v, u};

  always_ff @(posedge clk) begin
    if (xfer && !s1.upd) begin
      tex_mem[s1.taddr] <= s1.tval;
    end
    if (xfer && s1.upd) begin
      tex_q <= tex_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid && s1.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && s1.upd) begin
      pix2   <= s1.pix;
      depth2 <= s1.depth;
    end
  end

  assign s2  = '{pix: pix2, depth: depth2, texel: tex_q};
  assign trd = '{rd: xfer && s1.upd, pix: s1.pix};

`ifndef SYNTH
  a_load_drops: assert property (@(posedge clk) disable iff (rst)
    (xfer && !s1.upd) |=> !s2_valid)
    else $error("texel load transaction went past the texture stage");
`endif

endmodule

@@ rtl/ttt_trail_stage.sv @@
module ttt_trail_stage #(
  parameter int PIXEL_COUNT = ttt_pkg::PixelCountDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  ttt_pkg::trail_rd_t trd,
  input  logic               s2_valid,
  output logic               s2_ready,
  input  ttt_pkg::tex_out_t  s2,
  ttt_result_if.source       result,
  output logic               busy
);
  import ttt_pkg::*;

  localparam int StoreDepth = (PIXEL_COUNT > (1 << PixW)) ? (1 << PixW) : PIXEL_COUNT;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  byte_t            trail_mem [StoreDepth];
  byte_t            trail_q;
  logic [AddrW-1:0] clr_addr;

  logic             hit2;
  byte_t            hit_val2;
  byte_t            old2;

  logic             s3_valid;
  logic [PixW-1:0]  pix3;
  byte_t            old3;
  byte_t            color3;

  logic             out_valid;
  logic [PixW-1:0]  out_index;
  byte_t            out_value;

  logic             en4;
  logic             s3_ready;
  logic             xfer3;
  logic [ByteW:0]   sum;
  byte_t            new_value;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  byte_t            wr_data;

  assign en4       = !out_valid || result.ready;
  assign s3_ready  = !s3_valid || en4;
  assign s2_ready  = s3_ready;
  assign xfer3     = s3_valid && en4;
  assign sum       = {1'b0, FadeTab[old3]} + {1'b0, color3};
  assign new_value = sum[ByteW] ? '1 : sum[ByteW-1:0];
  assign old2      = hit2 ? hit_val2 : trail_q;

  assign wr_en   = busy || xfer3;
  assign wr_addr = busy ? clr_addr : pix3[AddrW-1:0];
  assign wr_data = busy ? '0 : new_value;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      trail_mem[wr_addr] <= wr_data;
    end
    if (trd.rd) begin
      trail_q <= trail_mem[trd.pix[AddrW-1:0]];
    end
  end

  // bypass a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (trd.rd) begin
      hit2     <= xfer3 && (pix3 == trd.pix);
      hit_val2 <= new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AddrW'(StoreDepth - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AddrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (en4) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      old3   <= (xfer3 && (pix3 == s2.pix)) ? new_value : old2;
      color3 <= s2.texel + s2.depth;
      pix3   <= s2.pix;
    end
    if (xfer3) begin
      out_index <= pix3;
      out_value <= new_value;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_index   = out_index;
  assign result.pixel_value = out_value;

`ifndef SYNTH
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!s3_valid && !out_valid && !trd.rd))
    else $error("pixel transaction in flight during trail clear");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("trail clear restarted");

  a_sat_floor: assert property (@(posedge clk) disable iff (rst)
    xfer3 |-> (new_value >= color3))
    else $error("trail value below fresh color");
`endif

endmodule

@@ rtl/tunnel_texture_trail_update.sv @@
// Tunnel feedback-trail pixel engine. Item transactions load the 64K texture (mode 0),
// load a pixel's angle and depth (mode 1), update a pixel's trail (mode 2) or advance
// the scroll (mode 3); only an update of a pixel below PIXEL_COUNT yields a result
// transaction carrying the pixel index and its new trail value. The pipeline takes one
// transaction per cycle while not stalled; an update passes the map read at acceptance,
// then the texture and trail read, fade and add with forwarding, and the result
// register, and stalls on the result side hold the stages without loss.
// After reset the trail memory is swept to zero one entry per cycle,
// min(PIXEL_COUNT, 16384) entries, with item ready held low.
module tunnel_texture_trail_update #(
  parameter int PIXEL_COUNT = ttt_pkg::PixelCountDefault
) (
  input  logic         clk,
  input  logic         rst,
  ttt_item_if.sink     item,
  ttt_result_if.source result
);
  import ttt_pkg::*;

  logic      busy;
  logic      s1_valid;
  logic      s1_ready;
  map_out_t  s1;
  logic      s2_valid;
  logic      s2_ready;
  tex_out_t  s2;
  trail_rd_t trd;

  ttt_map_stage #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .busy     (busy),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  ttt_tex_stage u_tex (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .trd      (trd)
  );

  ttt_trail_stage #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_trail (
    .clk      (clk),
    .rst      (rst),
    .trd      (trd),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .result   (result),
    .busy     (busy)
  );

endmodule

@@ sim/tunnel_texture_trail_update_checker.sv @@
module tunnel_texture_trail_update_checker
  import ttt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ttt_item_if   item,
  ttt_result_if result,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic [PixW-1:0] pix;
    byte_t           value;
  } trail_result_t;

  byte_t         texel_mem [1 << TexAw];
  byte_t         angle_mem [PixelCountDefault];
  byte_t         depth_mem [PixelCountDefault];
  byte_t         trail_mem [PixelCountDefault];
  byte_t         scroll;
  trail_result_t trail_results_q [$];

  function automatic byte_t faded_trail(byte_t old, byte_t texel, byte_t depth);
    byte_t color;
    int    next;
    color = texel + depth;
    next  = (int'(old) * FadeMul) / FadeDiv + int'(color);
    return (next > (1 << ByteW) - 1) ? '1 : byte_t'(next);
  endfunction

  always @(posedge clk) begin
    trail_result_t   got;
    trail_result_t   want;
    logic [PixW-1:0] p;
    byte_t           u;
    byte_t           v;
    if (rst) begin
      foreach (trail_mem[i]) trail_mem[i] = '0;
      scroll     = '0;
      fail_count = 0;
      trail_results_q.delete();
    end else begin
      if (item.valid && item.ready) begin
        p = item.pixel_index;
        case (item.mode)
          ModeTexel: texel_mem[item.texel_address] = item.texel_value;
          ModeMap: begin
            if (p < PixelCountDefault) begin
              angle_mem[p] = item.angle_value;
              depth_mem[p] = item.depth_value;
            end
          end
          ModeUpdate: begin
            if (p < PixelCountDefault) begin
              u = angle_mem[p] + scroll;
              v = depth_mem[p] + scroll;
              trail_mem[p] = faded_trail(trail_mem[p], texel_mem[{v, u}], depth_mem[p]);
              trail_results_q.push_back('{p, trail_mem[p]});
            end
          end
          ModeScroll: scroll = scroll + 1'b1;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got = '{result.out_index, result.pixel_value};
        if (trail_results_q.size() == 0) begin
          $error("result transaction with no update pending: out_index %0d pixel_value %0d",
                 got.pix, got.value);
          fail_count++;
        end else begin
          want = trail_results_q.pop_front();
          if (got.pix !== want.pix) begin
            $error("out_index: expected %0d, actual %0d", want.pix, got.pix);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("pixel_value: expected %0d, actual %0d", want.value, got.value);
            fail_count++;
          end
        end
      end
    end
    pending = trail_results_q.size();
  end

endmodule

@@ sim/tunnel_texture_trail_update_test.sv @@
module tunnel_texture_trail_update_test;
  import ttt_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int RandomSteps = 1450;
  localparam int HoldCycles  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  logic calm = 1'b0;
  logic hold_request = 1'b0;

  bit              tex_loaded   [1 << TexAw];
  bit              map_loaded   [PixelCountDefault];
  byte_t           angle_shadow [PixelCountDefault];
  byte_t           depth_shadow [PixelCountDefault];
  byte_t           scroll_shadow = '0;
  logic [PixW-1:0] mapped_q [$];

  ttt_item_if   item ();
  ttt_result_if result ();

  tunnel_texture_trail_update dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  tunnel_texture_trail_update_checker trail_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : drain_side
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  task automatic push_item(input logic [ModeW-1:0] m, input logic [PixW-1:0] p,
                           input logic [TexAw-1:0] ta, input byte_t tv, input byte_t av,
                           input byte_t dv);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 10) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid         <= 1'b1;
    item.mode          <= m;
    item.pixel_index   <= p;
    item.texel_address <= ta;
    item.texel_value   <= tv;
    item.angle_value   <= av;
    item.depth_value   <= dv;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    case (m)
      ModeTexel: tex_loaded[ta] = 1'b1;
      ModeMap: begin
        if (!map_loaded[p]) mapped_q.push_back(p);
        map_loaded[p]   = 1'b1;
        angle_shadow[p] = av;
        depth_shadow[p] = dv;
      end
      ModeScroll: scroll_shadow = scroll_shadow + 1'b1;
      default: ;
    endcase
  endtask

  task automatic load_texel(input logic [TexAw-1:0] ta, input byte_t tv);
    push_item(ModeTexel, PixW'($urandom), ta, tv, ByteW'($urandom), ByteW'($urandom));
  endtask

  task automatic load_map(input logic [PixW-1:0] p, input byte_t av, input byte_t dv);
    push_item(ModeMap, p, TexAw'($urandom), ByteW'($urandom), av, dv);
  endtask

  task automatic tick();
    push_item(ModeScroll, PixW'($urandom), TexAw'($urandom), ByteW'($urandom),
              ByteW'($urandom), ByteW'($urandom));
  endtask

  // load the texel the update will fetch if it was never written
  task automatic update_pixel(input logic [PixW-1:0] p);
    byte_t u;
    byte_t v;
    u = angle_shadow[p] + scroll_shadow;
    v = depth_shadow[p] + scroll_shadow;
    if (!tex_loaded[{v, u}]) load_texel({v, u}, ByteW'($urandom));
    push_item(ModeUpdate, p, TexAw'($urandom), ByteW'($urandom), ByteW'($urandom),
              ByteW'($urandom));
  endtask

  initial begin : stimulus
    int sel;
    int hot_span;
    logic [PixW-1:0] p;
    item.valid         = 1'b0;
    item.mode          = ModeTexel;
    item.pixel_index   = '0;
    item.texel_address = '0;
    item.texel_value   = '0;
    item.angle_value   = '0;
    item.depth_value   = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    load_texel('0, 8'h00);
    load_texel('1, 8'hFF);
    load_map('0, 8'h00, 8'h00);
    update_pixel('0);
    load_map('1, 8'hFF, 8'hFF);
    repeat (4) update_pixel('1);
    tick();
    update_pixel('0);
    load_map(14'h2AAA, 8'h55, 8'hAA);
    load_map(14'h1555, 8'hAA, 8'h55);
    update_pixel(14'h2AAA);
    update_pixel(14'h1555);
    update_pixel(14'h2AAA);
    tick();
    tick();
    update_pixel('1);
    load_map('0, 8'hFE, 8'h01);
    update_pixel('0);

    for (int k = 0; k < RandomSteps; k++) begin
      calm = (k >= 900 && k < 1150);
      if (k == 500) hold_request = 1'b1;
      if (k == 1400) begin
        @(negedge clk);
        item.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      hot_span = (mapped_q.size() < 8) ? mapped_q.size() : 8;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if ($urandom_range(0, 99) < 75) p = mapped_q[$urandom_range(0, hot_span - 1)];
        else p = mapped_q[$urandom_range(0, mapped_q.size() - 1)];
        update_pixel(p);
      end else if (sel < 60) begin
        if ($urandom_range(0, 99) < 40) p = mapped_q[$urandom_range(0, hot_span - 1)];
        else p = PixW'($urandom);
        load_map(p, ByteW'($urandom), ByteW'($urandom));
      end else if (sel < 80) begin
        load_texel(TexAw'($urandom), ByteW'($urandom));
      end else begin
        tick();
      end
    end

    @(negedge clk);
    item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ttt_pkg.sv
rtl/ttt_if.sv
rtl/ttt_map_stage.sv
rtl/ttt_tex_stage.sv
rtl/ttt_trail_stage.sv
rtl/tunnel_texture_trail_update.sv
sim/tunnel_texture_trail_update_checker.sv
sim/tunnel_texture_trail_update_test.sv
